// File: rtl/ars_pkg.sv
// Shared types and constants for the adaptive resolution step block.
// No dependencies; every other file in rtl/ imports this package.
package ars_pkg;

    localparam int TS_W    = 40;
    localparam int MS_W    = 16;
    localparam int RUNG_W  = 12;
    localparam int DIM_W   = 13;
    localparam int CNT_W   = 8;
    localparam int ACT_W   = 2;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 16;
    localparam int PROD_W  = DIM_W + RUNG_W;

    localparam logic [ACT_W-1:0] ACT_NONE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DOWN = 2'd1;
    localparam logic [ACT_W-1:0] ACT_UP   = 2'd2;

    localparam logic [RUNG_W-1:0] RUNG_HIGH = 12'd3200;
    localparam logic [RUNG_W-1:0] RUNG_MID  = 12'd2560;
    localparam logic [RUNG_W-1:0] RUNG_LOW  = 12'd1920;

    localparam logic [CIDX_W-1:0] REG_RELEASE_BUDGET = 3'd0;
    localparam logic [CIDX_W-1:0] REG_ENCODE_BUDGET  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_BREACH_SAMPLES = 3'd2;
    localparam logic [CIDX_W-1:0] REG_UPGRADE_WINDOW = 3'd3;
    localparam logic [CIDX_W-1:0] REG_INITIAL_RUNG   = 3'd4;
    localparam logic [CIDX_W-1:0] REG_NATIVE_WIDTH   = 3'd5;
    localparam logic [CIDX_W-1:0] REG_NATIVE_HEIGHT  = 3'd6;

    localparam logic [MS_W-1:0]  RST_RELEASE_BUDGET = 16'd100;
    localparam logic [MS_W-1:0]  RST_ENCODE_BUDGET  = 16'd33;
    localparam logic [CNT_W-1:0] RST_BREACH_SAMPLES = 8'd3;
    localparam logic [MS_W-1:0]  RST_UPGRADE_WINDOW = 16'd5000;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

    // One classified observation handed from the front to the back
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [RUNG_W-1:0] rung;
        logic              breached;
        logic [CNT_W-1:0]  breach_count;
        logic [TS_W-1:0]   stable_dur;
    } decision_t;

    function automatic logic [RUNG_W-1:0] clamp_rung(input logic [RUNG_W-1:0] r);
        if (r == RUNG_LOW || r == RUNG_MID || r == RUNG_HIGH) begin
            return r;
        end
        return RUNG_HIGH;
    endfunction

    // Round down to even, never below two
    function automatic logic [DIM_W-1:0] even_floor2(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] e;
        e = {v[DIM_W-1:1], 1'b0};
        return (e < 13'd2) ? 13'd2 : e;
    endfunction

endpackage

// File: rtl/ars_front.sv
// Front end: configuration registers, breach classification and rung control.
// Depends on ars_pkg; pushes one decision_t per accepted observation.
module ars_front
    import ars_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CDATA_W-1:0]  cfg_data,
    input  logic                obs_valid,
    output logic                obs_ready,
    input  logic [TS_W-1:0]     timestamp_ms,
    input  logic                link_blocked,
    input  logic [MS_W-1:0]     queue_age_ms,
    input  logic [MS_W-1:0]     capture_encode_ms,
    input  logic [MS_W-1:0]     encode_ms,
    input  logic                q_full,
    output logic                q_push,
    output decision_t           q_data,
    output logic [DIM_W-1:0]    native_width,
    output logic [DIM_W-1:0]    native_height
);

    logic [MS_W-1:0]   release_budget_reg, release_budget_next;
    logic [MS_W-1:0]   encode_budget_reg, encode_budget_next;
    logic [CNT_W-1:0]  breach_samples_reg, breach_samples_next;
    logic [MS_W-1:0]   upgrade_window_reg, upgrade_window_next;
    logic [RUNG_W-1:0] initial_rung_reg, initial_rung_next;
    logic [DIM_W-1:0]  native_width_reg, native_width_next;
    logic [DIM_W-1:0]  native_height_reg, native_height_next;

    logic [RUNG_W-1:0] rung_reg, rung_next;
    logic [CNT_W-1:0]  bcnt_reg, bcnt_next;
    logic [TS_W-1:0]   ss_reg, ss_next;
    logic              ss_valid_reg, ss_valid_next;

    logic              accept;
    logic              breached;
    logic [CNT_W-1:0]  bcnt_inc;
    logic [TS_W-1:0]   ss_eff;
    logic [TS_W-1:0]   elapsed;
    logic              ts_ahead;
    logic [ACT_W-1:0]  action;
    logic [TS_W-1:0]   dur;

    assign obs_ready = !q_full;
    assign accept    = obs_valid && !q_full;
    assign q_push    = accept;

    assign breached = link_blocked
                   || (queue_age_ms > release_budget_reg)
                   || (capture_encode_ms > release_budget_reg)
                   || (encode_ms > encode_budget_reg);

    assign bcnt_inc = (bcnt_reg == CNT_MAX) ? CNT_MAX : bcnt_reg + 8'd1;
    assign ss_eff   = ss_valid_reg ? ss_reg : timestamp_ms;
    assign ts_ahead = timestamp_ms >= ss_eff;
    assign elapsed  = timestamp_ms - ss_eff;

    always_comb
    begin
        release_budget_next = release_budget_reg;
        encode_budget_next  = encode_budget_reg;
        breach_samples_next = breach_samples_reg;
        upgrade_window_next = upgrade_window_reg;
        initial_rung_next   = initial_rung_reg;
        native_width_next   = native_width_reg;
        native_height_next  = native_height_reg;
        rung_next           = rung_reg;
        bcnt_next           = bcnt_reg;
        ss_next             = ss_reg;
        ss_valid_next       = ss_valid_reg;
        action              = ACT_NONE;
        dur                 = '0;

        if (cfg_we) begin
            case (cfg_index)
                REG_RELEASE_BUDGET: release_budget_next = cfg_data;
                REG_ENCODE_BUDGET:  encode_budget_next  = cfg_data;
                REG_BREACH_SAMPLES: breach_samples_next = cfg_data[CNT_W-1:0];
                REG_UPGRADE_WINDOW: upgrade_window_next = cfg_data;
                REG_INITIAL_RUNG:
                begin
                    initial_rung_next = clamp_rung(cfg_data[RUNG_W-1:0]);
                    rung_next         = clamp_rung(cfg_data[RUNG_W-1:0]);
                    bcnt_next         = '0;
                    ss_next           = '0;
                    ss_valid_next     = 1'b0;
                end
                REG_NATIVE_WIDTH:
                begin
                    if (cfg_data[DIM_W-1:0] != native_width_reg) begin
                        native_width_next = cfg_data[DIM_W-1:0];
                        bcnt_next         = '0;
                        ss_next           = '0;
                        ss_valid_next     = 1'b0;
                    end
                end
                REG_NATIVE_HEIGHT:
                begin
                    if (cfg_data[DIM_W-1:0] != native_height_reg) begin
                        native_height_next = cfg_data[DIM_W-1:0];
                        bcnt_next          = '0;
                        ss_next            = '0;
                        ss_valid_next      = 1'b0;
                    end
                end
                default: ;
            endcase
        end else if (accept) begin
            ss_valid_next = 1'b1;
            ss_next       = ss_eff;
            if (breached) begin
                ss_next   = timestamp_ms;
                bcnt_next = bcnt_inc;
                if (bcnt_inc >= breach_samples_reg && rung_reg > RUNG_LOW) begin
                    rung_next = (rung_reg == RUNG_HIGH) ? RUNG_MID : RUNG_LOW;
                    bcnt_next = '0;
                    action    = ACT_DOWN;
                end
            end else begin
                bcnt_next = '0;
                if (rung_reg < initial_rung_reg && ts_ahead
                    && elapsed >= {{(TS_W-MS_W){1'b0}}, upgrade_window_reg}) begin
                    rung_next = (rung_reg == RUNG_LOW) ? RUNG_MID : RUNG_HIGH;
                    ss_next   = timestamp_ms;
                    action    = ACT_UP;
                end
            end
            // start moved to now on breach or upgrade: duration is zero
            if (!breached && action == ACT_NONE && ts_ahead) begin
                dur = elapsed;
            end
        end
    end

    assign q_data.action       = action;
    assign q_data.rung         = rung_next;
    assign q_data.breached     = breached;
    assign q_data.breach_count = bcnt_next;
    assign q_data.stable_dur   = dur;

    assign native_width  = native_width_reg;
    assign native_height = native_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            release_budget_reg <= RST_RELEASE_BUDGET;
            encode_budget_reg  <= RST_ENCODE_BUDGET;
            breach_samples_reg <= RST_BREACH_SAMPLES;
            upgrade_window_reg <= RST_UPGRADE_WINDOW;
            initial_rung_reg   <= RUNG_HIGH;
            native_width_reg   <= '0;
            native_height_reg  <= '0;
            rung_reg           <= RUNG_HIGH;
            bcnt_reg           <= '0;
            ss_reg             <= '0;
            ss_valid_reg       <= 1'b0;
        end else begin
            release_budget_reg <= release_budget_next;
            encode_budget_reg  <= encode_budget_next;
            breach_samples_reg <= breach_samples_next;
            upgrade_window_reg <= upgrade_window_next;
            initial_rung_reg   <= initial_rung_next;
            native_width_reg   <= native_width_next;
            native_height_reg  <= native_height_next;
            rung_reg           <= rung_next;
            bcnt_reg           <= bcnt_next;
            ss_reg             <= ss_next;
            ss_valid_reg       <= ss_valid_next;
        end
    end

endmodule

// File: rtl/ars_fifo.sv
// Short decision queue between the front and the back.
// Depends on ars_pkg for decision_t.
module ars_fifo
    import ars_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  decision_t push_data,
    output logic      full,
    input  logic      pop,
    output decision_t pop_data,
    output logic      empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    decision_t         entry_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/ars_back.sv
// Back end: encode size by multiply and radix-2 long division, and the output register.
// Depends on ars_pkg; pops decision_t records from the queue.
module ars_back
    import ars_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  decision_t          q_data,
    output logic               q_pop,
    input  logic [DIM_W-1:0]   native_width,
    input  logic [DIM_W-1:0]   native_height,
    output logic               res_valid,
    input  logic               res_ready,
    output decision_t          res_rec,
    output logic [DIM_W-1:0]   res_width,
    output logic [DIM_W-1:0]   res_height
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;
    localparam int QW = RUNG_W;
    localparam logic [3:0] LAST_STEP = 4'(QW - 1);

    logic [1:0]         state_reg, state_next;
    decision_t          rec_reg;
    logic [DIM_W-1:0]   rem_reg, rem_next;
    logic [QW-1:0]      low_reg;
    logic [QW-1:0]      quo_reg, quo_next;
    logic [3:0]         step_reg;
    logic [DIM_W-1:0]   width_reg, width_next;
    logic [DIM_W-1:0]   height_reg, height_next;

    logic               wide;
    logic [DIM_W-1:0]   longest;
    logic [DIM_W-1:0]   shortest;
    logic [PROD_W-1:0]  product;
    logic [DIM_W:0]     trial;
    logic [DIM_W:0]     trial_diff;
    logic               ge;
    logic [DIM_W-1:0]   scaled;

    assign wide     = native_width >= native_height;
    assign longest  = wide ? native_width : native_height;
    assign shortest = wide ? native_height : native_width;
    assign product  = PROD_W'(shortest) * PROD_W'(rec_reg.rung);

    // Remainder stays below the divisor, so one compare and subtract per bit
    assign trial      = {rem_reg, low_reg[QW-1]};
    assign trial_diff = trial - {1'b0, longest};
    assign ge         = trial >= {1'b0, longest};
    assign rem_next   = ge ? trial_diff[DIM_W-1:0] : trial[DIM_W-1:0];
    assign quo_next   = {quo_reg[QW-2:0], ge};
    assign scaled     = even_floor2({1'b0, quo_next});

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (native_width == '0 || native_height == '0) begin
            width_next  = '0;
            height_next = '0;
        end else if (longest <= {1'b0, rec_reg.rung}) begin
            width_next  = even_floor2(native_width);
            height_next = even_floor2(native_height);
        end else if (wide) begin
            width_next  = {1'b0, rec_reg.rung};
            height_next = scaled;
        end else begin
            width_next  = scaled;
            height_next = {1'b0, rec_reg.rung};
        end
    end

    assign q_pop = (state_reg == ST_IDLE) && !q_empty;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (!q_empty) state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (step_reg == LAST_STEP) state_next = ST_OUT;
            ST_OUT:  if (res_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty) begin
                    rec_reg <= q_data;
                end
            end
            ST_MUL:
            begin
                rem_reg  <= product[PROD_W-1:QW];
                low_reg  <= product[QW-1:0];
                quo_reg  <= '0;
                step_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg  <= rem_next;
                low_reg  <= {low_reg[QW-2:0], 1'b0};
                quo_reg  <= quo_next;
                step_reg <= step_reg + 4'd1;
                if (step_reg == LAST_STEP) begin
                    width_reg  <= width_next;
                    height_reg <= height_next;
                end
            end
            default: ;
        endcase
    end

    assign res_valid  = (state_reg == ST_OUT);
    assign res_rec    = rec_reg;
    assign res_width  = width_reg;
    assign res_height = height_reg;

endmodule

// File: rtl/adaptive_resolution_step.sv
// Top level of the adaptive resolution step controller.
// Depends on ars_pkg, ars_front, ars_fifo and ars_back.
//
// Latency-driven rung controller: every observation yields exactly one decision
// (action, rung 3200/2560/1920, even encode size, breach flag and count, stable
// duration), in order. The front classifies an observation and updates the rung
// in the cycle it is accepted, then queues the decision; it accepts one per cycle
// while the queue (QUEUE_DEPTH entries) has room. The back sizes the encode
// frame with a multiply step and twelve long-division steps: it pops a decision
// from the head of the queue while idle, runs the multiply and division states,
// then presents the decision on the output and holds it until out_ready. It takes
// no new decision until the last one has left the output, so output stalls hold
// back the queue. Configuration writes are always taken (cfg_ready is tied high)
// and are to be issued only while no decision is pending.
module adaptive_resolution_step
    import ars_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CIDX_W-1:0]   cfg_index,
    input  logic [CDATA_W-1:0]  cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [TS_W-1:0]     timestamp_ms,
    input  logic                link_blocked,
    input  logic [MS_W-1:0]     queue_age_ms,
    input  logic [MS_W-1:0]     capture_encode_ms,
    input  logic [MS_W-1:0]     encode_ms,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [ACT_W-1:0]    action,
    output logic [RUNG_W-1:0]   edge_limit,
    output logic [DIM_W-1:0]    encode_width,
    output logic [DIM_W-1:0]    encode_height,
    output logic                budget_breached,
    output logic                stream_restart,
    output logic [CNT_W-1:0]    breach_count,
    output logic [TS_W-1:0]     stable_duration_ms
);

    decision_t          push_data;
    decision_t          head_data;
    decision_t          res_rec;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;
    logic [DIM_W-1:0]   native_width;
    logic [DIM_W-1:0]   native_height;

    assign cfg_ready = 1'b1;

    ars_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .obs_valid         (in_valid),
        .obs_ready         (in_ready),
        .timestamp_ms      (timestamp_ms),
        .link_blocked      (link_blocked),
        .queue_age_ms      (queue_age_ms),
        .capture_encode_ms (capture_encode_ms),
        .encode_ms         (encode_ms),
        .q_full            (q_full),
        .q_push            (push),
        .q_data            (push_data),
        .native_width      (native_width),
        .native_height     (native_height)
    );

    ars_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (head_data),
        .empty     (q_empty)
    );

    ars_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (head_data),
        .q_pop         (pop),
        .native_width  (native_width),
        .native_height (native_height),
        .res_valid     (out_valid),
        .res_ready     (out_ready),
        .res_rec       (res_rec),
        .res_width     (encode_width),
        .res_height    (encode_height)
    );

    assign action             = res_rec.action;
    assign edge_limit         = res_rec.rung;
    assign budget_breached    = res_rec.breached;
    assign stream_restart     = (res_rec.action != ACT_NONE);
    assign breach_count       = res_rec.breach_count;
    assign stable_duration_ms = res_rec.stable_dur;

    // A downgrade comes only from a breach and restarts the count
    a_down_on_breach: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_DOWN
        |-> budget_breached && breach_count == '0 && edge_limit != RUNG_HIGH)
        else $error("downgrade without breach or with stale count");

    // An upgrade comes only from a clean observation and restarts the window
    a_up_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == ACT_UP
        |-> !budget_breached && stable_duration_ms == '0 && edge_limit != RUNG_LOW)
        else $error("upgrade on breach or without window restart");

    // The divider path always leaves even dimensions
    a_even_size: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !encode_width[0] && !encode_height[0])
        else $error("odd encode dimension");

endmodule
